/* sv/b64_pkg.sv */
package b64_pkg;

	localparam int MAX_RES = 4;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// decode classes beyond the 0..63 alphabet values
	localparam logic [6:0] CODE_PAD = 7'd64;
	localparam logic [6:0] CODE_BAD = 7'd65;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic REG_DIRECTION = 1'b0;

	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       last;
		logic       bad;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [2:0]         cnt;
	} bundle_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [5:0] carry;
	} core_stat_t;

	typedef struct packed {
		logic [2:0] rem;
	} ob_stat_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	function automatic logic [6:0] dec_value(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] v;
		d = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			v = {1'b0, d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			v = {1'b0, d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			v = {1'b0, d[5:0]};
		end else if (c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h2F) begin
			v = 7'd63;
		end else if (c == PAD_CHAR) begin
			v = CODE_PAD;
		end else begin
			v = CODE_BAD;
		end
		return v;
	endfunction

endpackage

/* sv/b64_core.sv */
module b64_core import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dir,
	input  logic       clear,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output bundle_t    bundle,
	output core_stat_t stat
);

	logic [1:0] phase_q;
	logic [5:0] carry_q;
	logic [1:0] phase_d;
	logic [5:0] carry_d;
	logic [6:0] v;

	always_comb begin
		bundle  = '0;
		phase_d = phase_q;
		carry_d = carry_q;
		v       = dec_value(in_byte);
		if (dir == DIR_ENCODE) begin
			unique case (phase_q)
				2'd1: begin
					bundle.res[0] = '{enc_char({carry_q[1:0], in_byte[7:4]}), 1'b1, 1'b0, 1'b0};
					carry_d = {2'b00, in_byte[3:0]};
					phase_d = 2'd2;
					bundle.cnt = 3'd1;
					if (in_last) begin
						bundle.res[1] = '{enc_char({in_byte[3:0], 2'b00}), 1'b1, 1'b0, 1'b0};
						bundle.res[2] = '{PAD_CHAR, 1'b1, 1'b1, 1'b0};
						bundle.cnt = 3'd3;
					end
				end
				2'd2: begin
					bundle.res[0] = '{enc_char({carry_q[3:0], in_byte[7:6]}), 1'b1, 1'b0, 1'b0};
					bundle.res[1] = '{enc_char(in_byte[5:0]), 1'b1, in_last, 1'b0};
					bundle.cnt = 3'd2;
					carry_d = '0;
					phase_d = 2'd0;
				end
				// phase three never arises; treat it as the start of a group
				2'd0, 2'd3: begin
					bundle.res[0] = '{enc_char(in_byte[7:2]), 1'b1, 1'b0, 1'b0};
					carry_d = {4'b0000, in_byte[1:0]};
					phase_d = 2'd1;
					bundle.cnt = 3'd1;
					if (in_last) begin
						bundle.res[1] = '{enc_char({in_byte[1:0], 4'b0000}), 1'b1, 1'b0, 1'b0};
						bundle.res[2] = '{PAD_CHAR, 1'b1, 1'b0, 1'b0};
						bundle.res[3] = '{PAD_CHAR, 1'b1, 1'b1, 1'b0};
						bundle.cnt = 3'd4;
					end
				end
			endcase
		end else begin
			if (v == CODE_BAD) begin
				bundle.res[0] = '{8'h00, 1'b0, in_last, 1'b1};
				bundle.cnt = 3'd1;
			end else if (v != CODE_PAD) begin
				phase_d = phase_q + 2'd1;
				unique case (phase_q)
					2'd0: carry_d = v[5:0];
					2'd1: begin
						bundle.res[0] = '{{carry_q, v[5:4]}, 1'b1, in_last, 1'b0};
						bundle.cnt = 3'd1;
						carry_d = {2'b00, v[3:0]};
					end
					2'd2: begin
						bundle.res[0] = '{{carry_q[3:0], v[5:2]}, 1'b1, in_last, 1'b0};
						bundle.cnt = 3'd1;
						carry_d = {4'b0000, v[1:0]};
					end
					2'd3: begin
						bundle.res[0] = '{{carry_q[1:0], v[5:0]}, 1'b1, in_last, 1'b0};
						bundle.cnt = 3'd1;
						carry_d = '0;
					end
				endcase
			end
			// close the message with a marker when nothing else carries the end
			if (in_last && bundle.cnt == 3'd0) begin
				bundle.res[0] = '{8'h00, 1'b0, 1'b1, 1'b0};
				bundle.cnt = 3'd1;
			end
		end
		if (in_last) begin
			phase_d = '0;
			carry_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			carry_q <= '0;
		end else if (clear) begin
			phase_q <= '0;
			carry_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

	assign stat = '{phase_q, carry_q};

endmodule

/* sv/b64_outbuf.sv */
module b64_outbuf import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  bundle_t    bundle,
	output logic       can_load,
	output logic       m_tvalid,
	input  logic       m_tready,
	output res_t       head,
	output ob_stat_t   stat
);

	res_t [MAX_RES-1:0] res_q;
	logic [2:0]         rem_q;
	logic [1:0]         idx_q;
	logic               pop;

	assign m_tvalid = (rem_q != 3'd0);
	assign pop      = m_tvalid && m_tready;
	// take a new request when empty or while the final result of the current one leaves
	assign can_load = (rem_q == 3'd0) || (rem_q == 3'd1 && m_tready);
	assign head     = res_q[idx_q];
	assign stat     = '{rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= bundle.cnt;
			idx_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle.res;
		end
	end

endmodule

/* sv/base64_stream_codec.sv */
// Base64 codec (standard A-Z a-z 0-9 + / alphabet, '=' padding) on byte streams.
// Write direction (register 0, bit 0) while idle: 0 encodes bytes to characters,
// 1 decodes characters to bytes; the write also restarts the group. s_tlast ends
// a message: encode flushes and pads, decode drops leftover bits. Each input
// item yields zero to four results, which leave one per cycle on the master
// side while m_tready is high; m_tuser[0] marks a data-carrying result,
// m_tuser[1] a bad character. An item is taken every clock while m_tready is
// high if it yields at most one result; an item with more results holds the
// input while the single result port drains the four-entry buffer. The next
// item is taken in the cycle that the last result of the previous one leaves.
module base64_stream_codec import b64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [0] has_data, [1] bad_char
	output logic        m_tlast
);

	logic       dir_q;
	logic       cfg_wr;
	logic       accept;
	logic       can_load;
	bundle_t    bundle;
	core_stat_t core_stat;
	ob_stat_t   ob_stat;
	res_t       head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
	assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, dir_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
		end else if (cfg_wr) begin
			dir_q <= pwdata[0];
		end
	end

	assign s_tready = can_load;
	assign accept   = s_tvalid && s_tready;

	b64_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.dir     (dir_q),
		.clear   (cfg_wr),
		.accept  (accept),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.bundle  (bundle),
		.stat    (core_stat)
	);

	b64_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.bundle   (bundle),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head),
		.stat     (ob_stat)
	);

	assign m_tdata = head.data;
	assign m_tuser = {head.bad, head.has_data};
	assign m_tlast = head.last;

`ifndef NO_ASSERTIONS
	a_ready_only_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (ob_stat.rem <= 3'd1))
		else $error("input taken while results still queued");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_stat.rem <= 3'(MAX_RES))
		else $error("result count beyond buffer depth");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
		else $error("marker result carries data");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (core_stat.phase == 2'd0 && core_stat.carry == 6'd0))
		else $error("group state not cleared at end of message");
`endif

endmodule

/* verif/tb_base64_stream_codec.sv */
module tb_base64_stream_codec;
	import b64_pkg::*;

	localparam logic [2:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// codec state as predicted from the accepted traffic
	logic        cur_dir;
	logic [1:0]  grp_phase;
	logic [5:0]  grp_carry;
	res_t        pending_out[$];
	int          mismatch_cnt;
	bit          quiet;
	int          rdy_hold;

	base64_stream_codec u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		return ALPHABET[8*(63-v) +: 8];
	endfunction

	// 0..63 for an alphabet character, 64 for pad, 65 for anything else
	function automatic int b64_index(input logic [7:0] c);
		int k;
		int idx;
		idx = (c == PAD_CHAR) ? 64 : 65;
		for (k = 0; k < 64; k++)
			if (b64_char(k[5:0]) == c)
				idx = k;
		return idx;
	endfunction

	function automatic void push_out(input logic [7:0] d, input logic hd, input logic lst,
			input logic bd);
		res_t r;
		r.data     = d;
		r.has_data = hd;
		r.last     = lst;
		r.bad      = bd;
		pending_out = {pending_out, r};
	endfunction

	function automatic void codec_predict(input logic [7:0] b, input logic lst);
		logic [1:0] ph;
		logic [5:0] v6;
		int         v;
		int         n;
		ph = grp_phase;
		n = 0;
		if (cur_dir == DIR_ENCODE) begin
			if (ph == 2'd3)
				ph = 2'd0;
			case (ph)
				2'd0: begin
					push_out(b64_char(b[7:2]), 1'b1, 1'b0, 1'b0);
					grp_carry = {4'b0, b[1:0]};
					grp_phase = 2'd1;
					if (lst) begin
						push_out(b64_char({grp_carry[1:0], 4'b0}), 1'b1, 1'b0, 1'b0);
						push_out(PAD_CHAR, 1'b1, 1'b0, 1'b0);
						push_out(PAD_CHAR, 1'b1, 1'b1, 1'b0);
					end
				end
				2'd1: begin
					push_out(b64_char({grp_carry[1:0], b[7:4]}), 1'b1, 1'b0, 1'b0);
					grp_carry = {2'b0, b[3:0]};
					grp_phase = 2'd2;
					if (lst) begin
						push_out(b64_char({grp_carry[3:0], 2'b0}), 1'b1, 1'b0, 1'b0);
						push_out(PAD_CHAR, 1'b1, 1'b1, 1'b0);
					end
				end
				default: begin
					push_out(b64_char({grp_carry[3:0], b[7:6]}), 1'b1, 1'b0, 1'b0);
					push_out(b64_char(b[5:0]), 1'b1, lst, 1'b0);
					grp_carry = 6'd0;
					grp_phase = 2'd0;
				end
			endcase
		end else begin
			v = b64_index(b);
			v6 = v[5:0];
			if (v == 65) begin
				push_out(8'h00, 1'b0, lst, 1'b1);
				n++;
			end else if (v < 64) begin
				case (ph)
					2'd0: grp_carry = v6;
					2'd1: begin
						push_out({grp_carry, v6[5:4]}, 1'b1, lst, 1'b0);
						grp_carry = {2'b0, v6[3:0]};
						n++;
					end
					2'd2: begin
						push_out({grp_carry[3:0], v6[5:2]}, 1'b1, lst, 1'b0);
						grp_carry = {4'b0, v6[1:0]};
						n++;
					end
					default: begin
						push_out({grp_carry[1:0], v6}, 1'b1, lst, 1'b0);
						grp_carry = 6'd0;
						n++;
					end
				endcase
				grp_phase = ph + 2'd1;
			end
			if (lst && n == 0)
				push_out(8'h00, 1'b0, 1'b1, 1'b0);
		end
		if (lst) begin
			grp_phase = 2'd0;
			grp_carry = 6'd0;
		end
	endfunction

	// predict on every accepted request, then check every accepted result
	always @(posedge clk) begin : mon
		res_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION) begin
				cur_dir   = pwdata[0];
				grp_phase = 2'd0;
				grp_carry = 6'd0;
			end
			if (s_tvalid && s_tready)
				codec_predict(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (pending_out.size() == 0) begin
					$display("%0t: expected no result, actual %h user %b last %b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatch_cnt++;
				end else begin
					want = pending_out.pop_front();
					if (want.data !== m_tdata || want.has_data !== m_tuser[0] ||
							want.last !== m_tlast || want.bad !== m_tuser[1]) begin
						$display("%0t: expected %h user %b last %b, actual %h user %b last %b",
							$time, want.data, {want.bad, want.has_data}, want.last,
							m_tdata, m_tuser, m_tlast);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	// receiver: random ready/stall bursts, held high in the tail
	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (rdy_hold > 0) begin
			rdy_hold = rdy_hold - 1;
		end else if (m_tready) begin
			if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				rdy_hold = $urandom_range(1, 14) - 1;
			end else begin
				rdy_hold = $urandom_range(0, 20);
			end
		end else begin
			m_tready <= 1'b1;
			rdy_hold = $urandom_range(0, 30);
		end
	end

	// called and returns at a falling edge; valid stays high for a following request
	task automatic send_item(input logic [7:0] b, input logic lst);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string txt, input bit end_msg);
		int i;
		for (i = 0; i < txt.len(); i++)
			send_item(txt[i], end_msg && i == txt.len() - 1);
	endtask

	// hold off until every result is out and the block has settled
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [2:0] addr);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== cur_dir) begin
			$display("%0t: direction readback: expected %b, actual %b",
				$time, cur_dir, prdata[0]);
			mismatch_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_direction(input logic dir, input logic [30:0] junk);
		wait_drained();
		apb_write(ADDR_DIRECTION, {junk, dir});
		apb_read_check(ADDR_DIRECTION);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return b64_char(6'($urandom_range(0, 63)));
		else if (r < 88)
			return PAD_CHAR;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_config_regs();
		set_direction(DIR_DECODE, 31'h7FFF_FFFF);
		// a write outside the register map must leave direction alone
		apb_write(ADDR_UNMAPPED, 32'h0000_0000);
		apb_read_check(ADDR_DIRECTION);
		set_direction(DIR_ENCODE, 31'h7FFF_FFFF);
		set_direction(DIR_ENCODE, 31'h0);
	endtask

	task automatic test_encode_directed();
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("Man", 1'b1);
	endtask

	task automatic test_decode_directed();
		set_direction(DIR_DECODE, 31'h0);
		send_text("TQ==", 1'b1);
		send_text("TWE=", 1'b1);
		send_text("T!WFu", 1'b1);
		send_text("AZaz09+/", 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		// lone character that completes no byte ends the message
		send_text("B", 1'b1);
	endtask

	// a direction write restarts a half-done group
	task automatic test_direction_restart();
		set_direction(DIR_ENCODE, 31'h0);
		send_item(8'hA5, 1'b0);
		set_direction(DIR_ENCODE, 31'h0);
		send_item(8'h3C, 1'b1);
		set_direction(DIR_DECODE, 31'h0);
		send_text("TW", 1'b0);
		set_direction(DIR_DECODE, 31'h0);
		send_text("QQ", 1'b1);
	endtask

	task automatic run_random(input logic dir, input int count);
		int sent;
		int len;
		int k;
		set_direction(dir, 31'($urandom()));
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, 9);
			for (k = 0; k < len && sent < count; k++) begin
				if (dir == DIR_ENCODE)
					send_item(8'($urandom_range(0, 255)), k == len - 1);
				else
					send_item(pick_char(), k == len - 1);
				sent++;
			end
		end
	endtask

	task automatic test_random_encode();
		run_random(DIR_ENCODE, 60);
	endtask

	task automatic test_random_decode();
		run_random(DIR_DECODE, 60);
	endtask

	task automatic test_tail();
		quiet = 1'b1;
		run_random(DIR_ENCODE, 20);
		run_random(DIR_DECODE, 20);
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = 3'd0;
		pwdata       = 32'd0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		rdy_hold     = 0;
		quiet        = 1'b0;
		mismatch_cnt = 0;
		cur_dir      = DIR_ENCODE;
		grp_phase    = 2'd0;
		grp_carry    = 6'd0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_encode_directed();
		test_config_regs();
		test_decode_directed();
		test_direction_restart();
		test_random_encode();
		test_random_decode();
		test_tail();

		wait_drained();
		repeat (12) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("PASS base64_stream_codec");
		else
			$display("FAIL base64_stream_codec");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL base64_stream_codec");
		$finish;
	end

endmodule
